>>> rtl/bpsd_pkg.sv
// Shared types, codes and helpers of the BMP pixel stream decoder.
// No dependencies; imported by every module of the block except bpsd_ram.
package bpsd_pkg;

  localparam int MAX_WIDTH_DEF       = 8192;
  localparam int MAX_HEIGHT_DEF      = 8192;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int QUEUE_DEPTH         = 4;

  // Input modes
  localparam logic [1:0] MODE_PAL   = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  // Pixel formats
  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_4BPP  = 3'd1;
  localparam logic [2:0] FMT_8BPP  = 3'd2;
  localparam logic [2:0] FMT_24BPP = 3'd3;
  localparam logic [2:0] FMT_32BPP = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_FORMAT = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_FLIP   = 3'd3;
  localparam logic [2:0] REG_PCOUNT = 3'd4;
  localparam logic [2:0] REG_MASK_R = 3'd5;
  localparam logic [2:0] REG_MASK_G = 3'd6;
  localparam logic [2:0] REG_MASK_B = 3'd7;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_INDEX = 2'd1;
  localparam logic [1:0] ERR_MASK  = 2'd2;

  typedef enum logic [2:0] {
    JOB_PAL,
    JOB_INDEX,
    JOB_RGB,
    JOB_WORD,
    JOB_ERROR
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] data;
    logic [12:0] col;
    logic [12:0] row;
    logic        last;
    logic        done;
    logic [1:0]  err;
  } job_t;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [13:0] width;
    logic [13:0] height;
    logic        flip;
    logic [8:0]  pcount;
    logic [31:0] mask_r;
    logic [31:0] mask_g;
    logic [31:0] mask_b;
  } cfg_t;

  function automatic logic [4:0] low_bit(logic [31:0] m);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) pos = 5'(i);
    end
    return pos;
  endfunction

endpackage

>>> rtl/bpsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpsd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> rtl/bpsd_queue.sv
// Short job queue between the front sequencer and the back end.
// Depends on bpsd_pkg for job_t and QUEUE_DEPTH.
module bpsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bpsd_pkg::job_t push_job,
  output logic           not_full,
  input  logic           pop,
  output bpsd_pkg::job_t pop_job,
  output logic           not_empty
);
  import bpsd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign not_full  = count != (PW+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_job   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= PW'(wptr + 1'b1);
      if (pop)  rptr <= PW'(rptr + 1'b1);
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> not_full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> rtl/bpsd_front.sv
// Front sequencer: accepts items, tracks row and column position and
// turns each item into zero or more jobs for the queue. Depends on bpsd_pkg.
module bpsd_front #(
  parameter int MAX_WIDTH       = bpsd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = bpsd_pkg::MAX_HEIGHT_DEF,
  parameter int PALETTE_ENTRIES = bpsd_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     mode,
  input  logic [7:0]     palette_index,
  input  logic [7:0]     palette_blue,
  input  logic [7:0]     palette_green,
  input  logic [7:0]     palette_red,
  input  logic [7:0]     data_byte,
  input  bpsd_pkg::cfg_t cfg,
  output logic           q_push,
  output bpsd_pkg::job_t q_job,
  input  logic           q_ready
);
  import bpsd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int BW = $clog2(4 * MAX_WIDTH + 1);

  logic          pend;
  logic [1:0]    it_mode;
  logic [7:0]    it_pidx, it_pb, it_pg, it_pr, it_byte;
  logic [2:0]    slot;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [BW-1:0] bir, bir_next;
  logic [1:0]    k3, k3_next;
  logic [23:0]   pw, pw_next;
  logic          halted, halted_next;

  logic          step, finish;
  logic [CW-1:0] cur_w;
  logic [RW-1:0] cur_h, row_out;
  logic [BW-1:0] wb, unpadded, padded, bir_inc;
  logic [BW:0]   pad_sum;
  logic [2:0]    last_slot;
  logic [31:0]   mask_a;
  logic          mask_bad;
  logic          want_idx, want_col, emit_ok, done;
  logic [7:0]    idx;
  logic [23:0]   rgb;
  logic [31:0]   word;
  logic          is_word;

  assign step     = pend && q_ready;
  assign in_ready = !pend || finish;

  always_comb begin
    if (cfg.width == '0) cur_w = CW'(1);
    else if (32'(cfg.width) > 32'(MAX_WIDTH)) cur_w = CW'(MAX_WIDTH);
    else cur_w = CW'(cfg.width);
    if (cfg.height == '0) cur_h = RW'(1);
    else if (32'(cfg.height) > 32'(MAX_HEIGHT)) cur_h = RW'(MAX_HEIGHT);
    else cur_h = RW'(cfg.height);
  end

  always_comb begin
    wb = BW'(cur_w);
    unique case (cfg.fmt)
      FMT_1BPP:  unpadded = BW'((wb + BW'(7)) >> 3);
      FMT_4BPP:  unpadded = BW'((wb + BW'(1)) >> 1);
      FMT_8BPP:  unpadded = wb;
      FMT_24BPP: unpadded = BW'(wb + (wb << 1));
      default:   unpadded = BW'(wb << 2);
    endcase
    pad_sum = (BW+1)'({1'b0, unpadded} + (BW+1)'(3));
    padded  = BW'((pad_sum >> 2) << 2);
    unique case (cfg.fmt)
      FMT_1BPP: last_slot = 3'd7;
      FMT_4BPP: last_slot = 3'd1;
      default:  last_slot = 3'd0;
    endcase
    mask_a   = ~(cfg.mask_r | cfg.mask_g | cfg.mask_b);
    mask_bad = cfg.mask_r == '0 || cfg.mask_g == '0 || cfg.mask_b == '0 || mask_a == '0;
    row_out  = cfg.flip ? RW'(cur_h - RW'(1) - row) : row;
    bir_inc  = BW'(bir + 1'b1);
  end

  always_comb begin
    col_next    = col;
    row_next    = row;
    bir_next    = bir;
    k3_next     = k3;
    pw_next     = pw;
    halted_next = halted;
    finish      = 1'b0;
    q_push      = 1'b0;
    q_job       = '0;
    q_job.row   = 13'(row_out);
    q_job.col   = 13'(col);
    want_idx    = 1'b0;
    want_col    = 1'b0;
    idx         = it_byte;
    rgb         = '0;
    word        = '0;
    is_word     = 1'b0;
    emit_ok     = !halted && (col < cur_w);
    done        = (CW'(col + 1'b1) == cur_w) && (RW'(row + 1'b1) == cur_h);
    if (step) begin
      unique case (it_mode)
        MODE_PAL: begin
          finish = 1'b1;
          if (9'(it_pidx) < 9'(PALETTE_ENTRIES)) begin
            q_push     = 1'b1;
            q_job.kind = JOB_PAL;
            q_job.data = {it_pidx, it_pr, it_pg, it_pb};
          end
        end
        MODE_START: begin
          finish      = 1'b1;
          col_next    = '0;
          row_next    = '0;
          bir_next    = '0;
          k3_next     = '0;
          pw_next     = '0;
          halted_next = 1'b0;
        end
        MODE_DATA: begin
          if (slot == '0 && (halted || cfg.fmt > FMT_32BPP || row >= cur_h)) begin
            finish = 1'b1;
          end else if (slot == '0 && cfg.fmt == FMT_32BPP && mask_bad) begin
            // Unusable masks: one error result, clamped to the last column.
            finish      = 1'b1;
            halted_next = 1'b1;
            q_push      = 1'b1;
            q_job.kind  = JOB_ERROR;
            q_job.err   = ERR_MASK;
            q_job.last  = 1'b1;
            if (col >= cur_w) begin
              col_next  = CW'(cur_w - 1'b1);
              q_job.col = 13'(CW'(cur_w - 1'b1));
            end
          end else begin
            finish = slot == last_slot;
            if (bir < unpadded) begin
              unique case (cfg.fmt)
                FMT_1BPP: begin
                  want_idx = 1'b1;
                  idx      = {7'd0, it_byte[3'(3'd7 - slot)]};
                end
                FMT_4BPP: begin
                  want_idx = 1'b1;
                  idx      = slot[0] ? {4'd0, it_byte[3:0]} : {4'd0, it_byte[7:4]};
                end
                FMT_8BPP: want_idx = 1'b1;
                FMT_24BPP: begin
                  unique case (k3)
                    2'd0:    pw_next = {16'd0, it_byte};
                    2'd1:    pw_next = {8'd0, it_byte, pw[7:0]};
                    default: begin
                      want_col = 1'b1;
                      rgb      = {it_byte, pw[15:8], pw[7:0]};
                    end
                  endcase
                end
                default: begin
                  unique case (bir[1:0])
                    2'd0:    pw_next = {16'd0, it_byte};
                    2'd1:    pw_next = {8'd0, it_byte, pw[7:0]};
                    2'd2:    pw_next = {it_byte, pw[15:0]};
                    default: begin
                      want_col = 1'b1;
                      is_word  = 1'b1;
                      word     = {it_byte, pw};
                    end
                  endcase
                end
              endcase
            end
            if ((want_idx || want_col) && emit_ok) begin
              q_push = 1'b1;
              if (want_idx && (9'(idx) >= cfg.pcount || 9'(idx) >= 9'(PALETTE_ENTRIES))) begin
                q_job.kind  = JOB_ERROR;
                q_job.err   = ERR_INDEX;
                q_job.last  = 1'b1;
                halted_next = 1'b1;
              end else begin
                q_job.kind  = want_idx ? JOB_INDEX : (is_word ? JOB_WORD : JOB_RGB);
                q_job.data  = want_idx ? {24'd0, idx} : (is_word ? word : {8'd0, rgb});
                q_job.done  = done;
                q_job.last  = finish || done || (CW'(col + 1'b1) >= cur_w);
                col_next    = CW'(col + 1'b1);
                halted_next = done;
              end
            end
            // Row bookkeeping at the end of the byte.
            if (finish) begin
              bir_next = bir_inc;
              k3_next  = (k3 == 2'd2) ? 2'd0 : 2'(k3 + 1'b1);
              if (bir_inc >= padded) begin
                bir_next = '0;
                k3_next  = '0;
                col_next = '0;
                pw_next  = '0;
                row_next = RW'(row + 1'b1);
              end
            end
          end
        end
        default: finish = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_mode <= mode;
      it_pidx <= palette_index;
      it_pb   <= palette_blue;
      it_pg   <= palette_green;
      it_pr   <= palette_red;
      it_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= 1'b0;
      slot   <= '0;
      col    <= '0;
      row    <= '0;
      bir    <= '0;
      k3     <= '0;
      pw     <= '0;
      halted <= 1'b0;
    end else begin
      if (in_valid && in_ready) pend <= 1'b1;
      else if (finish)          pend <= 1'b0;
      if (finish)    slot <= '0;
      else if (step) slot <= 3'(slot + 1'b1);
      col    <= col_next;
      row    <= row_next;
      bir    <= bir_next;
      k3     <= k3_next;
      pw     <= pw_next;
      halted <= halted_next;
    end
  end

endmodule

>>> rtl/bpsd_back.sv
// Back end: palette memory, channel extraction and the output register.
// Depends on bpsd_pkg and bpsd_ram.
module bpsd_back #(
  parameter int PALETTE_ENTRIES = bpsd_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  bpsd_pkg::job_t q_job,
  output logic           q_pop,
  input  bpsd_pkg::cfg_t cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic [7:0]     alpha,
  output logic [12:0]    pixel_column,
  output logic [12:0]    pixel_row,
  output logic           last_of_burst,
  output logic           image_done,
  output logic [1:0]     error_code
);
  import bpsd_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic        bv;
  job_t        bjob;
  logic        b_adv;
  logic [23:0] rdata;
  logic [31:0] mask_a, w;
  logic [7:0]  r_c, g_c, b_c, a_c;

  assign b_adv = bv && (!out_valid || out_ready);
  assign q_pop = q_valid && (!bv || b_adv);

  bpsd_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk   (clk),
    .we    (q_pop && q_job.kind == JOB_PAL),
    .waddr (q_job.data[24 +: AW]),
    .wdata (q_job.data[23:0]),
    .re    (q_pop && q_job.kind == JOB_INDEX),
    .raddr (q_job.data[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    mask_a = ~(cfg.mask_r | cfg.mask_g | cfg.mask_b);
    w      = bjob.data;
    unique case (bjob.kind)
      JOB_INDEX: {r_c, g_c, b_c, a_c} = {rdata, 8'hFF};
      JOB_RGB:   {r_c, g_c, b_c, a_c} = {bjob.data[23:0], 8'hFF};
      JOB_WORD: begin
        r_c = 8'((w & cfg.mask_r) >> low_bit(cfg.mask_r));
        g_c = 8'((w & cfg.mask_g) >> low_bit(cfg.mask_g));
        b_c = 8'((w & cfg.mask_b) >> low_bit(cfg.mask_b));
        a_c = 8'((w & mask_a) >> low_bit(mask_a));
      end
      default:   {r_c, g_c, b_c, a_c} = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) bjob <= q_job;
    if (b_adv) begin
      red           <= r_c;
      green         <= g_c;
      blue          <= b_c;
      alpha         <= a_c;
      pixel_column  <= bjob.col;
      pixel_row     <= bjob.row;
      last_of_burst <= bjob.last;
      image_done    <= bjob.done;
      error_code    <= bjob.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop)      bv <= q_job.kind != JOB_PAL;
      else if (b_adv) bv <= 1'b0;
      if (b_adv)          out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/bmp_pixel_stream_decoder.sv
// Top level of the BMP pixel stream decoder: configuration registers and
// the front sequencer, job queue and back end. Depends on all other rtl files.
//
// Usage: the input channel (in_valid/in_ready) carries three kinds of
// transaction selected by mode: a palette entry write, one raw byte of the
// pixel-data section, or a start-of-image marker that rewinds the position.
// The output channel (out_valid/out_ready) carries decoded pixels with their
// column and destination row; last_of_burst marks the final pixel caused by
// one byte and image_done the last pixel of the image.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Throughput: one transaction per cycle for 8, 24 and 32 bpp bytes, palette
// writes and start markers while the queue has room; a 4 bpp or 1 bpp byte is
// held while the front sequencer steps through its pixels, one job per cycle.
// An accepted byte reaches the output through the front step, the queue pop
// with palette read and the output register.
// A stalled receiver holds the output register; the queue absorbs up to four
// jobs before the front stops and in_ready drops.
// Reset clears the position, the halt flag, the queue and restores default
// configuration; palette contents are undefined until written.
module bmp_pixel_stream_decoder #(
  parameter int MAX_WIDTH       = bpsd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = bpsd_pkg::MAX_HEIGHT_DEF,
  parameter int PALETTE_ENTRIES = bpsd_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  palette_index,
  input  logic [7:0]  palette_blue,
  input  logic [7:0]  palette_green,
  input  logic [7:0]  palette_red,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [12:0] pixel_column,
  output logic [12:0] pixel_row,
  output logic        last_of_burst,
  output logic        image_done,
  output logic [1:0]  error_code
);
  import bpsd_pkg::*;

  cfg_t cfg;
  logic q_push, q_ready, q_valid, q_pop;
  job_t push_job, pop_job;

  // Hold configuration; each write replaces one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt    <= FMT_8BPP;
      cfg.width  <= 14'd1;
      cfg.height <= 14'd1;
      cfg.flip   <= 1'b1;
      cfg.pcount <= 9'd256;
      cfg.mask_r <= 32'hFF00_0000;
      cfg.mask_g <= 32'h00FF_0000;
      cfg.mask_b <= 32'h0000_FF00;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FORMAT: cfg.fmt    <= cfg_data[2:0];
        REG_WIDTH:  cfg.width  <= cfg_data[13:0];
        REG_HEIGHT: cfg.height <= cfg_data[13:0];
        REG_FLIP:   cfg.flip   <= cfg_data[0];
        REG_PCOUNT: cfg.pcount <= cfg_data[8:0];
        REG_MASK_R: cfg.mask_r <= cfg_data;
        REG_MASK_G: cfg.mask_g <= cfg_data;
        REG_MASK_B: cfg.mask_b <= cfg_data;
      endcase
    end
  end

  // Front: classify transactions, advance position, emit jobs.
  bpsd_front #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .palette_index (palette_index),
    .palette_blue  (palette_blue),
    .palette_green (palette_green),
    .palette_red   (palette_red),
    .data_byte     (data_byte),
    .cfg           (cfg),
    .q_push        (q_push),
    .q_job         (push_job),
    .q_ready       (q_ready)
  );

  // Decouple front and back so each can stall on its own.
  bpsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .not_full  (q_ready),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_valid)
  );

  // Back: palette lookup, channel unpacking, output register.
  bpsd_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_job         (pop_job),
    .q_pop         (q_pop),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .pixel_column  (pixel_column),
    .pixel_row     (pixel_row),
    .last_of_burst (last_of_burst),
    .image_done    (image_done),
    .error_code    (error_code)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for bmp_pixel_stream_decoder: directed corner cases, then random images.
// Loads the palette first and holds its own decoder model; depends on bpsd_pkg and the decoder RTL.
`timescale 1ns / 1ps
module tb;
  import bpsd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] FMT_UNUSED  = 3'd5;
  localparam int MAX_W = 8192;
  localparam int MAX_H = 8192;

  typedef struct {
    logic [7:0]  red, green, blue, alpha;
    logic [12:0] col, row;
    logic        last, done;
    logic [1:0]  err;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = MODE_PAL;
  logic [7:0] palette_index = '0, palette_blue = '0, palette_green = '0, palette_red = '0;
  logic [7:0] data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red, green, blue, alpha;
  logic [12:0] pixel_column, pixel_row;
  logic last_of_burst, image_done;
  logic [1:0] error_code;

  bmp_pixel_stream_decoder DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder model state and its copy of the configuration
  logic [2:0]  m_fmt;
  logic [13:0] m_width, m_height;
  logic        m_flip;
  logic [8:0]  m_pcount;
  logic [31:0] m_mask_r, m_mask_g, m_mask_b;
  logic [23:0] m_palette [256];
  int          m_col, m_row, m_byte, cur_w, cur_h;
  logic [31:0] m_partial;
  bit          m_halted;

  pixel_t pixel_q[$];
  int fail_count = 0;
  int items_sent = 0;
  int pixels_seen = 0;
  int images_run = 0;
  bit quiet = 1'b0;

  function automatic int lowest_set(logic [31:0] m);
    for (int i = 0; i < 32; i++) if (m[i]) return i;
    return 0;
  endfunction

  function automatic pixel_t make_pixel(int r, int g, int b, int a, bit done, logic [1:0] err);
    pixel_t p;
    p.red = r[7:0]; p.green = g[7:0]; p.blue = b[7:0]; p.alpha = a[7:0];
    p.col = m_col[12:0];
    p.row = m_flip ? 13'(cur_h - 1 - m_row) : m_row[12:0];
    p.last = 1'b0; p.done = done; p.err = err;
    return p;
  endfunction

  task automatic push_color(int r, int g, int b, int a);
    bit done;
    if (m_halted || m_col >= cur_w) return;
    done = (m_col + 1 == cur_w) && (m_row + 1 == cur_h);
    pixel_q.push_back(make_pixel(r, g, b, a, done, ERR_NONE));
    m_col++;
    if (done) m_halted = 1'b1;
  endtask

  task automatic push_index(int idx);
    logic [23:0] e;
    if (m_halted || m_col >= cur_w) return;
    if (idx >= m_pcount) begin
      pixel_q.push_back(make_pixel(0, 0, 0, 0, 1'b0, ERR_INDEX));
      m_halted = 1'b1;
      return;
    end
    e = m_palette[idx];
    push_color(e[23:16], e[15:8], e[7:0], 8'hFF);
  endtask

  // Work out the pixels that one accepted transaction produces
  task automatic decode_item(logic [1:0] md, logic [7:0] pidx, logic [7:0] pb,
                             logic [7:0] pg, logic [7:0] pr, logic [7:0] db);
    int base, unp, pad, k;
    logic [31:0] w, ma;
    base = pixel_q.size();
    if (md == MODE_PAL) begin
      m_palette[pidx] = {pr, pg, pb};
      return;
    end
    if (md == MODE_START) begin
      m_col = 0; m_row = 0; m_byte = 0; m_partial = '0; m_halted = 1'b0;
      return;
    end
    if (md != MODE_DATA || m_halted || m_fmt > FMT_32BPP) return;
    cur_w = (m_width == 0) ? 1 : (m_width > MAX_W ? MAX_W : m_width);
    cur_h = (m_height == 0) ? 1 : (m_height > MAX_H ? MAX_H : m_height);
    if (m_row >= cur_h) return;
    case (m_fmt)
      FMT_1BPP:  unp = (cur_w + 7) / 8;
      FMT_4BPP:  unp = (cur_w + 1) / 2;
      FMT_8BPP:  unp = cur_w;
      FMT_24BPP: unp = cur_w * 3;
      default:   unp = cur_w * 4;
    endcase
    pad = (unp + 3) & ~3;
    ma = ~(m_mask_r | m_mask_g | m_mask_b);
    if (m_fmt == FMT_32BPP && (m_mask_r == 0 || m_mask_g == 0 || m_mask_b == 0 || ma == 0)) begin
      if (m_col >= cur_w) m_col = cur_w - 1;
      pixel_q.push_back(make_pixel(0, 0, 0, 0, 1'b0, ERR_MASK));
      pixel_q[pixel_q.size() - 1].last = 1'b1;
      m_halted = 1'b1;
      return;
    end
    if (m_byte < unp) begin
      case (m_fmt)
        FMT_1BPP: for (int i = 0; i < 8; i++) push_index(db[7 - i]);
        FMT_4BPP: begin
          push_index(db[7:4]);
          push_index(db[3:0]);
        end
        FMT_8BPP: push_index(db);
        FMT_24BPP: begin
          k = m_byte % 3;
          if (k == 0) m_partial = {24'd0, db};
          else if (k == 1) m_partial[15:8] = db;
          else push_color(db, m_partial[15:8], m_partial[7:0], 8'hFF);
        end
        default: begin
          k = m_byte & 3;
          if (k == 0) m_partial = {24'd0, db};
          else if (k < 3) m_partial[8*k +: 8] = db;
          else begin
            w = {db, m_partial[23:0]};
            push_color((w & m_mask_r) >> lowest_set(m_mask_r),
                       (w & m_mask_g) >> lowest_set(m_mask_g),
                       (w & m_mask_b) >> lowest_set(m_mask_b),
                       (w & ma) >> lowest_set(ma));
          end
        end
      endcase
    end
    m_byte++;
    if (m_byte >= pad) begin
      m_byte = 0; m_col = 0; m_partial = '0; m_row++;
    end
    if (pixel_q.size() > base) pixel_q[pixel_q.size() - 1].last = 1'b1;
  endtask

  // Send one transaction; hold it until accepted, then idle for a random gap, which may be none
  task automatic send_item(logic [1:0] md, logic [7:0] pidx, logic [7:0] pb,
                           logic [7:0] pg, logic [7:0] pr, logic [7:0] db);
    int r, gap;
    in_valid <= 1'b1;
    mode <= md; palette_index <= pidx; palette_blue <= pb;
    palette_green <= pg; palette_red <= pr; data_byte <= db;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_item(md, pidx, pb, pg, pr, db);
    items_sent++;
    r = $urandom_range(99);
    gap = quiet ? 0 : (r < 60 ? 0 : (r < 95 ? $urandom_range(3, 1) : $urandom_range(40, 10)));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(logic [7:0] db);
    send_item(MODE_DATA, $urandom, $urandom, $urandom, $urandom, db);
  endtask

  task automatic send_start();
    send_item(MODE_START, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Hold the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FORMAT: m_fmt = val[2:0];
      REG_WIDTH:  m_width = val[13:0];
      REG_HEIGHT: m_height = val[13:0];
      REG_FLIP:   m_flip = val[0];
      REG_PCOUNT: m_pcount = val[8:0];
      REG_MASK_R: m_mask_r = val;
      REG_MASK_G: m_mask_g = val;
      default:    m_mask_b = val;
    endcase
  endtask

  // Drain all expected pixels, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic configure(logic [2:0] fmt, int w, int h, bit flip, int pc,
                           logic [31:0] mr = 32'hFF000000, logic [31:0] mg = 32'h00FF0000,
                           logic [31:0] mb = 32'h0000FF00);
    wait_idle();
    write_reg(REG_FORMAT, fmt);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_FLIP, flip);
    write_reg(REG_PCOUNT, pc);
    write_reg(REG_MASK_R, mr);
    write_reg(REG_MASK_G, mg);
    write_reg(REG_MASK_B, mb);
    cfg_write <= 1'b0;
  endtask

  // Fill every palette entry so no lookup ever hits an unwritten entry
  task automatic test_palette_load();
    for (int i = 0; i < 256; i++)
      send_item(MODE_PAL, i[7:0], $urandom, $urandom, $urandom, $urandom);
    send_item(MODE_PAL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(MODE_PAL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_directed();
    // One-pixel 8 bpp image, plus a trailing byte that must be dropped
    configure(FMT_8BPP, 1, 1, 1'b1, 256);
    send_start(); send_byte(8'h00); send_byte(8'hFF);
    // 24 bpp single pixel with padding
    configure(FMT_24BPP, 1, 1, 1'b0, 256);
    send_start(); send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'hFF);
    // Odd width at 4 bpp drops the low nibble
    configure(FMT_4BPP, 3, 1, 1'b0, 16);
    send_start(); send_byte(8'h0F); send_byte(8'hF0); send_byte(8'h00); send_byte(8'h00);
    // Palette index beyond the count, with an empty palette
    configure(FMT_8BPP, 4, 1, 1'b0, 0);
    send_start(); send_byte(8'h00);
    // Zero mask, then masks leaving no alpha bits
    configure(FMT_32BPP, 2, 1, 1'b0, 256, 32'h0, 32'h0000FF00, 32'h000000FF);
    send_start(); send_byte(8'hAA);
    configure(FMT_32BPP, 2, 1, 1'b0, 256, 32'hFFFF0000, 32'h0000FF00, 32'h000000FF);
    send_start(); send_byte(8'hAA);
    // Unused format ignores bytes; unused mode is ignored
    configure(FMT_UNUSED, 2, 1, 1'b0, 256);
    send_start(); send_byte(8'h55);
    send_item(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
    // Largest sizes with flip: first row lands on row 8191; clamped out-of-range width
    configure(FMT_1BPP, 8192, 8192, 1'b1, 2);
    send_start(); send_byte(8'hA5); send_byte(8'h5A);
    configure(FMT_1BPP, 14'h3FFF, 0, 1'b1, 1);
    send_start(); send_byte(8'h81);
  endtask

  task automatic test_random_images(int target);
    logic [2:0] fmt;
    logic [31:0] mr, mg, mb;
    int w, h, pc, unp, nbytes, r;
    while (items_sent < target) begin
      r = $urandom_range(99);
      fmt = 3'($urandom_range(4));
      w = (r < 5) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      h = $urandom_range(4, 1);
      pc = ($urandom_range(9) < 7) ? 256 : $urandom_range(256);
      mr = $urandom; mg = $urandom & ~mr; mb = $urandom & ~(mr | mg);
      if ($urandom_range(9) < 6) begin
        mr = 32'h00FF0000 << $urandom_range(1) * 8; mg = 32'h0000FF00; mb = 32'h000000FF;
        if (mr == 32'hFF000000) mr = 32'h00F00000 << 8;
      end
      configure(fmt, w, h, $urandom_range(1), pc, mr, mg, mb);
      quiet = ($urandom_range(3) == 0);
      images_run++;
      case (fmt)
        FMT_1BPP:  unp = (w + 7) / 8;
        FMT_4BPP:  unp = (w + 1) / 2;
        FMT_8BPP:  unp = w;
        FMT_24BPP: unp = w * 3;
        default:   unp = w * 4;
      endcase
      nbytes = ((unp + 3) & ~3) * h + $urandom_range(2);
      if (nbytes > 120) nbytes = 120;
      send_start();
      repeat (nbytes) begin
        r = $urandom_range(39);
        if (r == 0) send_item(MODE_PAL, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (r == 1) send_item(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (r == 2) send_start();
        else send_byte($urandom);
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver stalls: mostly ready, short holds, now and then a long one
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (quiet || $urandom_range(99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(2);
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare each output transaction with the oldest expected pixel
  always @(posedge clk) begin
    pixel_t e;
    if (!rst && out_valid && out_ready) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel at column %0d row %0d", pixel_column, pixel_row);
        fail_count++;
      end else begin
        e = pixel_q.pop_front();
        check_field("red", e.red, red);
        check_field("green", e.green, green);
        check_field("blue", e.blue, blue);
        check_field("alpha", e.alpha, alpha);
        check_field("pixel_column", e.col, pixel_column);
        check_field("pixel_row", e.row, pixel_row);
        check_field("last_of_burst", e.last, last_of_burst);
        check_field("image_done", e.done, image_done);
        check_field("error_code", e.err, error_code);
      end
    end
  end

  initial begin
    m_fmt = FMT_8BPP; m_width = 1; m_height = 1; m_flip = 1'b1; m_pcount = 256;
    m_mask_r = 32'hFF000000; m_mask_g = 32'h00FF0000; m_mask_b = 32'h0000FF00;
    m_col = 0; m_row = 0; m_byte = 0; m_partial = '0; m_halted = 1'b0;
    cur_w = 1; cur_h = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_palette_load();
    test_directed();
    test_random_images(360);
    wait_idle();
    repeat (40) @(posedge clk);
    if (pixel_q.size() != 0) begin
      $error("%0d expected pixels never arrived", pixel_q.size());
      fail_count++;
    end
    $display("Covered %0d transactions over %0d random images, %0d pixels checked.",
             items_sent, images_run, pixels_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
